/* design/ntm_pkg.sv */
package ntm_pkg;

  // Fixed build constants
  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam int unsigned SAMPLE_RATE      = 44100;
  localparam int unsigned SINE_TABLE_BITS  = 10;
  localparam int unsigned NOTE_COUNT       = 128;

  localparam int unsigned QUARTER   = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned NOTE_ID_W = $clog2(NOTE_COUNT);
  localparam int unsigned OCT_W     = $clog2((NOTE_COUNT - 1) / 12 + 1);
  localparam int unsigned CH_IDX_W  = 5;  // enough for up to 32 channels

  // Register reset values and limits
  localparam logic [14:0] VOLUME_MAX = 15'd32000;
  localparam logic [14:0] VOLUME_RST = 15'd8000;
  localparam logic [1:0]  WAVE_RST   = 2'd2;
  localparam logic [3:0]  CHANS_RST  = 4'd1;

  // Configuration register indexes
  localparam logic [1:0] REG_VOLUME   = 2'd0;
  localparam logic [1:0] REG_WAVEFORM = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_SQUARE,
    WAVE_SINE_SQ,
    WAVE_OCT_SQ
  } wave_e;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_NOTE_ON,
    ACT_REST,
    ACT_CLEAR
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOTE_SPLIT,
    ST_NOTE_LOAD,
    ST_PHASE,
    ST_LOOK,
    ST_SCALE,
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic                accept;
    logic                acc_clr;
    logic                note_split;
    logic                note_load;
    logic                phase_en;
    logic                look_en;
    logic                scale_en;
    logic                accum_en;
    logic                div_init;
    logic                div_step;
    logic                out_load;
    logic [CH_IDX_W-1:0] ch;
  } ntm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    in_valid;
    action_e act;
    logic    out_busy;
  } ntm_status_t;

  // Semitone ratios, Q16
  function automatic logic [63:0] semi_ratio(input int unsigned s);
    logic [63:0] r;
    case (s)
      0:       r = 64'd65536;
      1:       r = 64'd69433;
      2:       r = 64'd73562;
      3:       r = 64'd77936;
      4:       r = 64'd82570;
      5:       r = 64'd87480;
      6:       r = 64'd92682;
      7:       r = 64'd98193;
      8:       r = 64'd104032;
      9:       r = 64'd110218;
      10:      r = 64'd116772;
      default: r = 64'd123715;
    endcase
    return r;
  endfunction

  typedef logic [63:0] base_tab_t [12];

  // Per-semitone increment before the octave shift
  function automatic base_tab_t build_base();
    base_tab_t tab;
    for (int unsigned s = 0; s < 12; s++) begin
      tab[s] = ((64'd33 * semi_ratio(s)) << 31) / SAMPLE_RATE;
    end
    return tab;
  endfunction

  localparam base_tab_t SEMI_BASE = build_base();

  // Quarter-wave sine in Q15, odd Taylor polynomial in Q30
  function automatic logic [14:0] quarter_sine(input int unsigned t);
    logic [63:0] u, u2, p, s;
    u  = 64'(t) << (30 - (SINE_TABLE_BITS - 2));
    u2 = (u * u) >> 30;
    p  = 64'd5026995 - ((u2 * 64'd172272) >> 30);
    p  = 64'd85569306 - ((u2 * p) >> 30);
    p  = 64'd693598668 - ((u2 * p) >> 30);
    p  = 64'd1686629713 - ((u2 * p) >> 30);
    s  = (u * p) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[14:0];
  endfunction

  typedef logic [14:0] qsin_tab_t [QUARTER+1];

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int unsigned t = 0; t <= QUARTER; t++) begin
      tab[t] = quarter_sine(t);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

endpackage

/* design/note_tone_mixer_unit.sv */
// Note-on runs split and load states; rest and clear-counter end in the accept cycle.
// A tick walks the channels through phase, lookup, scale and accumulate: one shared
// 32x32 phase multiplier and one wave-times-volume multiplier feed a mix total of
// TW = 34 + clog2(NUM_CHANNELS+1) bits, then a one-bit-per-cycle divider forms the mix.
// One word is in work at a time; the output register lets the next word in while a
// sample waits. Reset is asynchronous, active low: channels off, counter zero.
module note_tone_mixer_unit #(
  parameter int unsigned NUM_CHANNELS = ntm_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // action[1:0], channel[4:2], note_number[11:5],
                                     // accidentals[15:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // sample[15:0]
  output logic        m_axis_tuser,  // clipped[0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);
  import ntm_pkg::*;

  ntm_cmd_t    cmd;
  ntm_status_t status;

  ntm_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  ntm_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

/* design/ntm_ctrl.sv */
module ntm_ctrl #(
  parameter int unsigned NUM_CHANNELS = ntm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ntm_pkg::ntm_status_t status_i,
  output ntm_pkg::ntm_cmd_t    cmd_o,
  output logic                 in_ready_o
);
  import ntm_pkg::*;

  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TW = 34 + $clog2(NUM_CHANNELS + 1);
  localparam int unsigned DW = TW - 15;
  localparam int unsigned SW = $clog2(DW + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   ch_q, ch_d;
  logic [SW-1:0]   step_q, step_d;
  logic            ch_last, step_last;

  assign ch_last   = (ch_q == CW'(NUM_CHANNELS - 1));
  assign step_last = (step_q == SW'(DW - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          if (status_i.act == ACT_TICK)         state_d = ST_PHASE;
          else if (status_i.act == ACT_NOTE_ON) state_d = ST_NOTE_SPLIT;
        end
      end
      ST_NOTE_SPLIT: state_d = ST_NOTE_LOAD;
      ST_NOTE_LOAD:  state_d = ST_IDLE;
      ST_PHASE:      state_d = ST_LOOK;
      ST_LOOK:       state_d = ST_SCALE;
      ST_SCALE:      state_d = ST_ACCUM;
      ST_ACCUM:      state_d = ch_last ? ST_DIV_INIT : ST_PHASE;
      ST_DIV_INIT:   state_d = ST_DIV;
      ST_DIV:        state_d = step_last ? ST_DONE : ST_DIV;
      ST_DONE:       state_d = status_i.out_busy ? ST_DONE : ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Outputs and counter updates
  always_comb begin
    cmd_o      = '0;
    cmd_o.ch   = CH_IDX_W'(ch_q);
    in_ready_o = 1'b0;
    ch_d       = ch_q;
    step_d     = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = status_i.in_valid;
        cmd_o.acc_clr = status_i.in_valid && (status_i.act == ACT_TICK);
        ch_d          = '0;
      end
      ST_NOTE_SPLIT: cmd_o.note_split = 1'b1;
      ST_NOTE_LOAD:  cmd_o.note_load  = 1'b1;
      ST_PHASE:      cmd_o.phase_en   = 1'b1;
      ST_LOOK:       cmd_o.look_en    = 1'b1;
      ST_SCALE:      cmd_o.scale_en   = 1'b1;
      ST_ACCUM: begin
        cmd_o.accum_en = 1'b1;
        ch_d           = ch_q + CW'(1);
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + SW'(1);
      end
      ST_DONE:       cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      step_q  <= step_d;
    end
  end

  // A result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_busy)
    else $error("result loaded while output busy");

  // Channel walk restarts at zero for every tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_clr |=> (ch_q == '0) && (state_q == ST_PHASE))
    else $error("channel walk did not start at channel zero");

  // Divider does not leave before its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && !step_last |=> (state_q == ST_DIV))
    else $error("divider left early");

endmodule

/* design/ntm_datapath.sv */
module ntm_datapath #(
  parameter int unsigned NUM_CHANNELS = ntm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic [15:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,
  output logic                 m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [14:0]          cfg_data_i,
  input  ntm_pkg::ntm_cmd_t    cmd_i,
  output ntm_pkg::ntm_status_t status_o
);
  import ntm_pkg::*;

  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TW = 34 + $clog2(NUM_CHANNELS + 1);
  localparam int unsigned DW = TW - 15;
  localparam int unsigned STB = SINE_TABLE_BITS;

  // Input word fields
  logic [1:0] in_act;
  logic [2:0] in_chan;
  logic [6:0] in_note;
  logic [3:0] in_acc;
  assign in_act  = s_axis_tdata[1:0];
  assign in_chan = s_axis_tdata[4:2];
  assign in_note = s_axis_tdata[11:5];
  assign in_acc  = s_axis_tdata[15:12];

  // Config registers
  logic [14:0] vol_q;
  logic [1:0]  wave_q;
  logic [3:0]  chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q   <= VOLUME_RST;
      wave_q  <= WAVE_RST;
      chans_q <= CHANS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VOLUME:   vol_q   <= (cfg_data_i > VOLUME_MAX) ? VOLUME_MAX : cfg_data_i;
        REG_WAVEFORM: wave_q  <= cfg_data_i[1:0];
        REG_CHANNELS: chans_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Channel state
  logic [31:0]             cnt_q;
  logic [31:0]             incr_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] en_q;
  logic [CW-1:0]           in_cidx, ch;
  logic                    in_chan_ok;

  assign in_cidx    = CW'(in_chan);
  assign in_chan_ok = (32'(in_chan) < NUM_CHANNELS);
  assign ch         = cmd_i.ch[CW-1:0];

  // Latched note fields
  logic [6:0]            note_q;
  logic [3:0]            acc_q;
  logic [CW-1:0]         nch_q;
  logic                  nch_ok_q;
  logic [OCT_W-1:0]      oct_q;
  logic [3:0]            semi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      note_q   <= in_note;
      acc_q    <= in_acc;
      nch_q    <= in_cidx;
      nch_ok_q <= in_chan_ok;
    end
  end

  // Note id with accidentals, clamped, then split into octave and semitone
  logic [7:0]              id_up;
  logic [1:0]              id_dn;
  logic [7:0]              id_diff;
  logic [NOTE_ID_W-1:0]    id_cl;
  logic [NOTE_ID_W+7:0]    id_recip;
  logic [OCT_W-1:0]        oct_d;

  always_comb begin
    id_up   = 8'(note_q) + 8'(acc_q[0]) + {6'd0, acc_q[1], 1'b0};
    id_dn   = 2'(acc_q[2]) + {acc_q[3], 1'b0};
    id_diff = id_up - 8'(id_dn);
    if (id_up < 8'(id_dn))                    id_cl = '0;
    else if (32'(id_diff) > NOTE_COUNT - 1)   id_cl = NOTE_ID_W'(NOTE_COUNT - 1);
    else                                      id_cl = NOTE_ID_W'(id_diff);
    // divide by twelve: times 171 over 2048, exact below 500
    id_recip = (NOTE_ID_W+8)'(id_cl) * (NOTE_ID_W+8)'(171);
    oct_d    = OCT_W'(id_recip >> 11);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.note_split) begin
      oct_q  <= oct_d;
      semi_q <= 4'(id_cl - NOTE_ID_W'(oct_d) * NOTE_ID_W'(12));
    end
  end

  logic [63:0] base_shift;
  assign base_shift = (SEMI_BASE[semi_q] << oct_q) >> 18;

  always_ff @(posedge clk_i) begin
    if (cmd_i.note_load && nch_ok_q) incr_q[nch_q] <= base_shift[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.note_load && nch_ok_q) en_q[nch_q] <= 1'b1;
      if (cmd_i.accept && action_e'(in_act) == ACT_REST && in_chan_ok)
        en_q[in_cidx] <= 1'b0;
      if (cmd_i.accept && action_e'(in_act) == ACT_CLEAR) cnt_q <= '0;
      else if (cmd_i.out_load)                           cnt_q <= cnt_q + 32'd1;
    end
  end

  // Phase stage
  logic [31:0] phase_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.phase_en) phase_q <= 32'(cnt_q * (en_q[ch] ? incr_q[ch] : 32'd0));
  end

  // Quarter-wave lookup
  logic [1:0]     quad;
  logic [STB-3:0] qoff;
  logic [STB-2:0] tq;
  logic [14:0]    rom_q;

  assign quad = phase_q[31 -: 2];
  assign qoff = phase_q[29 -: (STB-2)];
  assign tq   = quad[0] ? (STB-1)'(QUARTER) - (STB-1)'(qoff) : (STB-1)'(qoff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_en) rom_q <= QSIN_TAB[tq];
  end

  // Square sign straight from phase bits: positive in first half, off zero
  logic [3:0] sq_pos;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_pos[i] = (phase_q[31-i -: 2] == 2'b01) ||
                  ((phase_q[31-i -: 2] == 2'b00) && (phase_q[29-i -: (STB-2)] != '0));
    end
  end

  // Wave select and volume scale
  logic signed [18:0] sine_v, sq_v, oct_v, wave_v;
  logic signed [34:0] prod_q;

  always_comb begin
    sine_v = quad[1] ? -$signed({4'd0, rom_q}) : $signed({4'd0, rom_q});
    sq_v   = sq_pos[0] ? 19'sd32768 : -19'sd32768;
    oct_v  = '0;
    for (int i = 0; i < 4; i++) begin
      oct_v = oct_v + (sq_pos[i] ? 19'sd32768 : -19'sd32768);
    end
    case (wave_e'(wave_q))
      WAVE_SINE:    wave_v = sine_v;
      WAVE_SQUARE:  wave_v = sq_v;
      WAVE_SINE_SQ: wave_v = sine_v + sq_v;
      default:      wave_v = oct_v;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) prod_q <= 35'(wave_v) * 35'($signed({1'b0, vol_q}));
  end

  // Mix accumulator
  logic signed [TW-1:0] total_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr)                    total_q <= '0;
    else if (cmd_i.accum_en && en_q[ch])  total_q <= total_q + TW'(prod_q);
  end

  // Restoring divider on the magnitude over 2^15
  logic [TW-1:0] mag;
  logic [DW-1:0] dq_q;
  logic [3:0]    rem_q, dvs_q;
  logic          neg_q;
  logic [4:0]    trial;
  logic          fits;

  assign mag   = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);
  assign trial = {rem_q, dq_q[DW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dq_q  <= mag[TW-1:15];
      rem_q <= '0;
      dvs_q <= (chans_q == 4'd0) ? 4'd1 : chans_q;
      neg_q <= total_q[TW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? 4'(trial - {1'b0, dvs_q}) : trial[3:0];
      dq_q  <= {dq_q[DW-2:0], fits};
    end
  end

  // Saturate and output register
  logic [15:0] samp_d;
  logic        clip_d;
  always_comb begin
    if (!neg_q) begin
      clip_d = (dq_q > DW'(32767));
      samp_d = clip_d ? 16'h7FFF : dq_q[15:0];
    end else begin
      clip_d = (dq_q > DW'(32768));
      samp_d = clip_d ? 16'h8000 : 16'(-dq_q[15:0]);
    end
  end

  logic        mval_q;
  logic [15:0] msamp_q;
  logic        mclip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              mval_q <= 1'b0;
    else if (cmd_i.out_load)  mval_q <= 1'b1;
    else if (m_axis_tready)   mval_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      msamp_q <= samp_d;
      mclip_q <= clip_d;
    end
  end

  assign m_axis_tvalid     = mval_q;
  assign m_axis_tdata      = msamp_q;
  assign m_axis_tuser      = mclip_q;
  assign status_o.in_valid = s_axis_tvalid;
  assign status_o.act      = action_e'(in_act);
  assign status_o.out_busy = mval_q && !m_axis_tready;

  // Volume never exceeds its ceiling
  assert property (@(posedge clk_i) disable iff (!rst_ni) vol_q <= VOLUME_MAX)
    else $error("master volume above limit");

  // Divider remainder stays below the divisor while stepping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_step) |-> (rem_q < dvs_q))
    else $error("divider remainder out of range");

  // A clipped result carries a full-scale sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'h7FFF || m_axis_tdata == 16'h8000))
    else $error("clip flag without full-scale sample");

endmodule

/* verif/tb_note_tone_mixer_unit.sv */
module tb_note_tone_mixer_unit;
  import ntm_pkg::*;

  localparam int unsigned NCH = 8;

  // Expected samples in arrival order
  class mix_scoreboard;
    logic [15:0] sample_q[$];
    logic        clip_q[$];
    int unsigned errors;
    int unsigned checked;

    function void note_sample(logic [15:0] s, logic c);
      sample_q.push_back(s);
      clip_q.push_back(c);
    endfunction

    function void check_sample(logic [15:0] s, logic c);
      logic [15:0] es;
      logic ec;
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected word sample=%h clipped=%b", $realtime, s, c);
        errors++;
      end else begin
        es = sample_q.pop_front();
        ec = clip_q.pop_front();
        checked++;
        if (es !== s) begin
          $display("%0t: sample expected %h actual %h", $realtime, es, s);
          errors++;
        end
        if (ec !== c) begin
          $display("%0t: clipped expected %b actual %b", $realtime, ec, c);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [14:0] cfg_data_i;

  note_tone_mixer_unit DUT (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Predictor state
  logic [14:0] volume;
  wave_e       wave_sel;
  logic [3:0]  chan_div;
  logic [31:0] counter;
  logic [31:0] incr[NCH];
  logic        chan_on[NCH];

  mix_scoreboard sb;
  int unsigned ticks_sent;

  function automatic logic [63:0] ratio_q16(int unsigned s);
    logic [63:0] r[12];
    r = '{65536, 69433, 73562, 77936, 82570, 87480,
          92682, 98193, 104032, 110218, 116772, 123715};
    return r[s];
  endfunction

  function automatic logic [31:0] pitch_step(int id);
    logic [63:0] q;
    int oct, sh;
    if (id < 0) id = 0;
    if (id > 127) id = 127;
    oct = id / 12;
    q = ((64'd33 * ratio_q16(id % 12)) << 31) / 64'd44100;
    sh = oct - 18;
    if (sh >= 0) q = q << sh;
    else q = q >> (-sh);
    return q[31:0];
  endfunction

  function automatic int qsine(int unsigned t);
    logic [63:0] u, u2, p, s;
    u  = 64'(t) << 22;
    u2 = (u * u) >> 30;
    p  = 64'd5026995 - ((u2 * 64'd172272) >> 30);
    p  = 64'd85569306 - ((u2 * p) >> 30);
    p  = 64'd693598668 - ((u2 * p) >> 30);
    p  = 64'd1686629713 - ((u2 * p) >> 30);
    s  = (u * p) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return int'(s);
  endfunction

  function automatic int sine_at(logic [31:0] ph);
    logic [9:0] idx;
    int unsigned t;
    int m;
    idx = ph[31:22];
    t = idx[8] ? 256 - idx[7:0] : idx[7:0];
    m = qsine(t);
    return idx[9] ? -m : m;
  endfunction

  function automatic int sq(int s);
    return s > 0 ? 32768 : -32768;
  endfunction

  function automatic int wave_at(logic [31:0] ph);
    int s, acc;
    s = sine_at(ph);
    acc = 0;
    case (wave_sel)
      WAVE_SINE:    return s;
      WAVE_SQUARE:  return sq(s);
      WAVE_SINE_SQ: return s + sq(s);
      default: begin
        for (int i = 0; i < 4; i++) acc += sq(sine_at(ph << i));
        return acc;
      end
    endcase
  endfunction

  // Apply one word to the predictor
  task automatic predict_word(logic [15:0] w);
    action_e act;
    int id;
    longint total, dv, mix;
    logic c;
    act = action_e'(w[1:0]);
    case (act)
      ACT_NOTE_ON: begin
        id = w[11:5] + w[12] + 2 * w[13] - w[14] - 2 * w[15];
        incr[w[4:2]] = pitch_step(id);
        chan_on[w[4:2]] = 1'b1;
      end
      ACT_REST:  chan_on[w[4:2]] = 1'b0;
      ACT_CLEAR: counter = '0;
      default: begin
        total = 0;
        for (int i = 0; i < NCH; i++)
          if (chan_on[i])
            total += longint'(wave_at(counter * incr[i])) * longint'(volume);
        dv = (chan_div == 0 ? 1 : chan_div) * 32768;
        mix = total / dv;
        c = 1'b0;
        if (mix > 32767) begin
          mix = 32767; c = 1'b1;
        end else if (mix < -32768) begin
          mix = -32768; c = 1'b1;
        end
        counter = counter + 1;
        sb.note_sample(16'(mix), c);
        ticks_sent++;
      end
    endcase
  endtask

  // Register write while idle
  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_we_i  <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_VOLUME:   volume = val > VOLUME_MAX ? VOLUME_MAX : val;
      REG_WAVEFORM: wave_sel = wave_e'(val[1:0]);
      REG_CHANNELS: chan_div = val[3:0];
      default: ;
    endcase
  endtask

  // Stop sending and wait for every expected sample
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.sample_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Send one word; keeps tvalid high for back-to-back words
  int unsigned burst_left;
  task automatic send_word(logic [15:0] w);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(w);
    burst_left--;
  endtask

  function automatic logic [15:0] word(action_e a, int ch, int note, int acc);
    return {4'(acc), 7'(note), 3'(ch), 2'(a)};
  endfunction

  function automatic logic [15:0] rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return word(ACT_TICK, $urandom, $urandom, $urandom);
    if (r < 80) return word(ACT_NOTE_ON, $urandom, $urandom, $urandom);
    if (r < 95) return word(ACT_REST, $urandom, $urandom, $urandom);
    return word(ACT_CLEAR, $urandom, $urandom, $urandom);
  endfunction

  // Receiver: stalls on its own rhythm
  int unsigned rx_cnt;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata, m_axis_tuser);
      rx_cnt <= rx_cnt + 1;
      m_axis_tready <= (rx_cnt % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rx_cnt = 0;
    burst_left = 0;
    ticks_sent = 0;
    volume = VOLUME_RST;
    wave_sel = wave_e'(WAVE_RST);
    chan_div = CHANS_RST;
    counter = '0;
    for (int i = 0; i < NCH; i++) begin
      incr[i] = '0;
      chan_on[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, ROM ends, accidentals, zero crossings
    send_word(word(ACT_TICK, 0, 0, 0));
    send_word(word(ACT_NOTE_ON, 0, 0, 4'b1100));
    send_word(word(ACT_NOTE_ON, 1, 127, 4'b0011));
    send_word(word(ACT_NOTE_ON, 2, 57, 4'b1111));
    send_word(word(ACT_NOTE_ON, 7, 69, 4'b0101));
    send_word(word(ACT_TICK, 0, 0, 0));
    send_word(word(ACT_TICK, 5, 127, 15));
    send_word(word(ACT_TICK, 0, 0, 0));
    send_word(word(ACT_REST, 1, 0, 0));
    send_word(word(ACT_REST, 6, 0, 0));
    send_word(word(ACT_TICK, 0, 0, 0));
    send_word(word(ACT_CLEAR, 0, 0, 0));
    for (int i = 0; i < 8; i++) send_word(word(ACT_NOTE_ON, i, 100 + i, 0));
    send_word(word(ACT_TICK, 0, 0, 0));
    send_word(word(ACT_TICK, 0, 0, 0));
    drain();

    // Loudest square mix with divisor 0 (taken as 1) to force clipping
    write_reg(REG_VOLUME, 15'h7FFF);
    write_reg(REG_WAVEFORM, WAVE_SQUARE);
    write_reg(REG_CHANNELS, 15'd0);
    send_word(word(ACT_CLEAR, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_word(word(ACT_TICK, 0, 0, 0));
    drain();

    // Random phases across settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_VOLUME, ph == 0 ? 15'd0 : ph == 1 ? 15'd32000 : 15'($urandom));
      write_reg(REG_WAVEFORM, 15'(ph % 4));
      write_reg(REG_CHANNELS, ph == 2 ? 15'd15 : ph == 3 ? 15'd8 : 15'($urandom_range(0, 15)));
      for (int n = 0; n < 50; n++) send_word(rand_word());
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      drain();
    end

    s_axis_tvalid <= 1'b0;
    drain();
    $display("Sent %0d samples, checked %0d, over 10 random register settings",
             ticks_sent, sb.checked);
    $display("covering all waveforms, volume and divisor extremes, clipping and ROM ends.");
    if (sb.errors == 0 && sb.sample_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
